FILE: hdl/ucf_pkg.sv
// ----------------------------------------------------------------------------
// ucf_pkg
// Shared widths, codes and types of the utf-8 character count range filter.
// ----------------------------------------------------------------------------
package ucf_pkg;

  localparam int COUNT_BITS_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int BYTE_W     = 8;
  localparam int CHAR_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int HELD_DEPTH = 5;
  localparam int PTR_W      = 3;
  localparam int NEED_W     = 3;
  localparam int ONES_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_CHAR   = 2'd1;

  localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_CODE = 8'h80;
  localparam logic [ONES_W-1:0] MAX_LEAD_ONES = 4'd6;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    logic              is_cont;
    logic              is_lead;
    logic [NEED_W-1:0] need;
  } ucf_entry_t;

endpackage

FILE: hdl/ucf_if.sv
// ----------------------------------------------------------------------------
// ucf_in_if / ucf_out_if
// Valid/ready channels for raw bytes in and filtered results out.
// ----------------------------------------------------------------------------
interface ucf_in_if;
  import ucf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ucf_out_if;
  import ucf_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] kept_byte;
  logic [CHAR_W-1:0] char_count;
  logic              run_end;

  modport source (output valid, output kind, output kept_byte, output char_count,
                  output run_end, input ready);
  modport sink   (input valid, input kind, input kept_byte, input char_count,
                  input run_end, output ready);
endinterface

FILE: hdl/ucf_front.sv
// ----------------------------------------------------------------------------
// ucf_front
// Input stage: takes one byte per item and classifies it as plain, lead or
// continuation byte before handing it to the queue.
// ----------------------------------------------------------------------------
module ucf_front (
  input  logic                clk,
  input  logic                rst_n,
  ucf_in_if.sink              in_ch,
  output logic                push_v,
  output ucf_pkg::ucf_entry_t push_entry,
  input  logic                push_ok
);
  import ucf_pkg::*;

  logic       stage_v_r, stage_v_nxt;
  ucf_entry_t stage_r;
  ucf_entry_t cls;
  logic [ONES_W-1:0] ones;
  logic       stop;
  logic       accept;

  // leading ones of the byte
  always_comb begin
    ones = '0;
    stop = 1'b0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (!stop && in_ch.data_byte[BYTE_W-1-i]) begin
        ones = ones + ONES_W'(1);
      end else begin
        stop = 1'b1;
      end
    end
  end

  always_comb begin
    cls.data_byte = in_ch.data_byte;
    cls.last_byte = in_ch.last_byte;
    cls.is_cont   = (in_ch.data_byte & CONT_MASK) == CONT_CODE;
    cls.is_lead   = ones inside {[ONES_W'(2):MAX_LEAD_ONES]};
    cls.need      = NEED_W'(ones - ONES_W'(1));
  end

  assign in_ch.ready = !stage_v_r || push_ok;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_v      = stage_v_r;
  assign push_entry  = stage_r;

  always_comb begin
    stage_v_nxt = stage_v_r;
    if (accept) begin
      stage_v_nxt = 1'b1;
    end else if (push_ok) begin
      stage_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r <= cls;
    end
  end

endmodule

FILE: hdl/ucf_queue.sv
// ----------------------------------------------------------------------------
// ucf_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module ucf_queue #(
  parameter int DEPTH = ucf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_v,
  input  ucf_pkg::ucf_entry_t push_entry,
  output logic                push_ok,
  output logic                pop_v,
  output ucf_pkg::ucf_entry_t pop_entry,
  input  logic                pop
);
  import ucf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  ucf_entry_t     mem [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign push_ok   = count_r != CW'(DEPTH);
  assign pop_v     = count_r != '0;
  assign pop_entry = mem[rd_ptr_r];
  assign do_push   = push_v && push_ok;
  assign do_pop    = pop && pop_v;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: hdl/ucf_back.sv
// ----------------------------------------------------------------------------
// ucf_back
// Sequencer: assembles characters from queued bytes, numbers them, filters
// by character range and issues the results, one queued byte at a time.
// ----------------------------------------------------------------------------
module ucf_back #(
  parameter int COUNT_BITS = ucf_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_v,
  input  ucf_pkg::ucf_entry_t         q_entry,
  output logic                        q_pop,
  input  logic [ucf_pkg::CHAR_W-1:0]  first_char,
  input  logic [ucf_pkg::CHAR_W-1:0]  end_char,
  ucf_out_if.source                   out_ch
);
  import ucf_pkg::*;

  localparam int CMP_W = (COUNT_BITS > CHAR_W) ? COUNT_BITS : CHAR_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_CHAR  = 5'b00100,
    ST_FLUSH = 5'b01000,
    ST_SUM   = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  ucf_entry_t          cur_r, cur_nxt;
  logic                tail_r, tail_nxt;
  logic [PTR_W-1:0]    ptr_r, ptr_nxt;
  logic [PTR_W-1:0]    cnt_r, cnt_nxt;
  logic [NEED_W-1:0]   still_r, still_nxt;
  logic [COUNT_BITS-1:0] idx_r, idx_nxt;
  logic [BYTE_W-1:0]   held_r [HELD_DEPTH];

  logic                pend_v_r, pend_v_nxt;
  kind_t               pend_kind_r;
  logic [BYTE_W-1:0]   pend_byte_r;
  logic [CHAR_W-1:0]   pend_count_r;

  logic                out_valid_r, out_valid_nxt;
  kind_t               out_kind_r;
  logic [BYTE_W-1:0]   out_byte_r;
  logic [CHAR_W-1:0]   out_count_r;
  logic                out_run_end_r;

  logic                go, rel, adv, sum_clr, keep, push_pend, ld_out, ld_end;
  logic                held_we;
  logic [PTR_W-1:0]    held_wa;
  logic [BYTE_W-1:0]   held_wd;
  logic                cand_v;
  kind_t               cand_kind;
  logic [BYTE_W-1:0]   cand_byte;
  logic [NEED_W-1:0]   fin_need;
  logic [CMP_W-1:0]    idx_ext;

  assign go      = !out_valid_r || out_ch.ready;
  assign idx_ext = CMP_W'(idx_r);

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    tail_nxt  = tail_r;
    ptr_nxt   = ptr_r;
    cnt_nxt   = cnt_r;
    still_nxt = still_r;
    q_pop     = 1'b0;
    rel       = 1'b0;
    adv       = 1'b0;
    sum_clr   = 1'b0;
    held_we   = 1'b0;
    held_wa   = cnt_r;
    held_wd   = cur_r.data_byte;
    cand_v    = 1'b0;
    cand_kind = KIND_DATA;
    cand_byte = cur_r.data_byte;
    fin_need  = '0;
    if (go) begin
      case (state_r)
        ST_IDLE: begin
          rel = pend_v_r;
          if (q_v) begin
            q_pop   = 1'b1;
            cur_nxt = q_entry;
            if (still_r != '0) begin
              if (!q_entry.is_cont) begin
                // broken sequence
                ptr_nxt   = '0;
                tail_nxt  = 1'b0;
                state_nxt = ST_FLUSH;
              end else if (still_r == NEED_W'(1)) begin
                ptr_nxt   = '0;
                state_nxt = ST_CHAR;
              end else begin
                held_we   = 1'b1;
                held_wd   = q_entry.data_byte;
                cnt_nxt   = cnt_r + PTR_W'(1);
                still_nxt = still_r - NEED_W'(1);
                if (q_entry.last_byte) begin
                  ptr_nxt   = '0;
                  tail_nxt  = 1'b1;
                  state_nxt = ST_FLUSH;
                end
              end
            end else begin
              state_nxt = ST_START;
            end
          end
        end
        ST_START: begin
          if (!cur_r.is_lead) begin
            cand_v = 1'b1;
            adv    = 1'b1;
          end else begin
            held_we   = 1'b1;
            held_wa   = '0;
            cnt_nxt   = PTR_W'(1);
            still_nxt = cur_r.need;
            fin_need  = cur_r.need;
          end
          if (!cur_r.last_byte) begin
            state_nxt = ST_IDLE;
          end else if (fin_need != '0) begin
            // string ends inside a sequence
            ptr_nxt   = '0;
            tail_nxt  = 1'b1;
            state_nxt = ST_FLUSH;
          end else begin
            state_nxt = ST_SUM;
          end
        end
        ST_CHAR: begin
          cand_v = 1'b1;
          if (ptr_r != cnt_r) begin
            cand_byte = held_r[ptr_r];
            ptr_nxt   = ptr_r + PTR_W'(1);
          end else begin
            adv       = 1'b1;
            cnt_nxt   = '0;
            still_nxt = '0;
            state_nxt = cur_r.last_byte ? ST_SUM : ST_IDLE;
          end
        end
        ST_FLUSH: begin
          cand_v    = 1'b1;
          cand_byte = held_r[ptr_r];
          adv       = 1'b1;
          if (ptr_r == cnt_r - PTR_W'(1)) begin
            cnt_nxt   = '0;
            still_nxt = '0;
            state_nxt = tail_r ? ST_SUM : ST_START;
          end else begin
            ptr_nxt = ptr_r + PTR_W'(1);
          end
        end
        ST_SUM: begin
          cand_v    = 1'b1;
          cand_kind = KIND_SUMMARY;
          cand_byte = '0;
          sum_clr   = 1'b1;
          cnt_nxt   = '0;
          still_nxt = '0;
          state_nxt = ST_IDLE;
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  // saturating character index
  always_comb begin
    idx_nxt = idx_r;
    if (sum_clr) begin
      idx_nxt = '0;
    end else if (adv && !(&idx_r)) begin
      idx_nxt = idx_r + COUNT_BITS'(1);
    end
  end

  assign keep = (cand_kind == KIND_SUMMARY) ||
                ((idx_ext >= CMP_W'(first_char)) && (idx_ext < CMP_W'(end_char)));
  assign push_pend = cand_v && keep;

  // one result is held back until it is known whether it ends the item's run
  always_comb begin
    ld_out     = rel || (push_pend && pend_v_r);
    ld_end     = rel;
    pend_v_nxt = pend_v_r;
    if (rel) begin
      pend_v_nxt = 1'b0;
    end else if (push_pend) begin
      pend_v_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tail_r      <= 1'b0;
      ptr_r       <= '0;
      cnt_r       <= '0;
      still_r     <= '0;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tail_r      <= tail_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      still_r     <= still_nxt;
      idx_r       <= idx_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (held_we) begin
      held_r[held_wa] <= held_wd;
    end
    if (push_pend) begin
      pend_kind_r  <= cand_kind;
      pend_byte_r  <= cand_byte;
      pend_count_r <= idx_ext[CHAR_W-1:0];
    end
    if (ld_out) begin
      out_kind_r    <= pend_kind_r;
      out_byte_r    <= pend_byte_r;
      out_count_r   <= pend_count_r;
      out_run_end_r <= ld_end;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.kept_byte  = out_byte_r;
  assign out_ch.char_count = out_count_r;
  assign out_ch.run_end    = out_run_end_r;

  a_open_seq_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (still_r != '0) |-> (cnt_r != '0 && cnt_r <= PTR_W'(HELD_DEPTH)))
    else $error("open sequence without held bytes");

  a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> (cnt_r != '0 && ptr_r < cnt_r))
    else $error("flush pointer out of held range");

  a_summary_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_SUMMARY) |-> out_run_end_r)
    else $error("summary item not marked as run end");

  a_sum_clears_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM && go) |=> (idx_r == '0 && still_r == '0))
    else $error("counter not cleared after summary");

endmodule

FILE: hdl/utf8_char_count_range_filter_unit.sv
// ----------------------------------------------------------------------------
// utf8_char_count_range_filter_unit
// Splits a byte stream into utf-8 characters with lenient recovery, passes
// the bytes of characters in [first_char, end_char) and ends each string
// with a summary item holding the character count.
//
//   channel | dir | payload                                   | handshake
//   in_ch   | in  | data_byte, last_byte                      | valid/ready
//   out_ch  | out | kind, kept_byte, char_count, run_end      | valid/ready
//   cfg_*   | in  | cfg_index, cfg_data                       | cfg_we
//
// a plain or lead byte passes the idle and start states of the back
// sequencer; each held byte passed on or flushed and the summary take a state
// step of their own, a continuation byte only held is taken in idle. the
// sequencer takes a new byte only when done with the last; front stage and
// queue keep taking items while it or the output is stalled, until the queue
// is full. synchronous active-low reset clears counters, queue, valid flags.
// ----------------------------------------------------------------------------
module utf8_char_count_range_filter_unit #(
  parameter int COUNT_BITS  = ucf_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = ucf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ucf_in_if.sink                         in_ch,
  ucf_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [ucf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ucf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ucf_pkg::*;

  logic [CHAR_W-1:0] first_char_r, first_char_nxt;
  logic [CHAR_W-1:0] end_char_r, end_char_nxt;

  logic       push_v, push_ok;
  ucf_entry_t push_entry;
  logic       pop_v, pop;
  ucf_entry_t pop_entry;

  always_comb begin
    first_char_nxt = first_char_r;
    end_char_nxt   = end_char_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_CHAR: first_char_nxt = cfg_data[CHAR_W-1:0];
        REG_END_CHAR:   end_char_nxt   = cfg_data[CHAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_char_r <= '0;
      end_char_r   <= '1;
    end else begin
      first_char_r <= first_char_nxt;
      end_char_r   <= end_char_nxt;
    end
  end

  ucf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_v     (push_v),
    .push_entry (push_entry),
    .push_ok    (push_ok)
  );

  ucf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_v     (push_v),
    .push_entry (push_entry),
    .push_ok    (push_ok),
    .pop_v      (pop_v),
    .pop_entry  (pop_entry),
    .pop        (pop)
  );

  ucf_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_v        (pop_v),
    .q_entry    (pop_entry),
    .q_pop      (pop),
    .first_char (first_char_r),
    .end_char   (end_char_r),
    .out_ch     (out_ch)
  );

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the utf-8 character count range filter against a cycle-free
// predictor: directed character forms and window settings, and random
// strings under three idling patterns.
// ----------------------------------------------------------------------------
module tb;
  import ucf_pkg::*;

  localparam int CHAR_CNT_BITS  = 16;
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 32;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 50;

  localparam logic [CFG_IDX_W-1:0]  REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0]  REG_SPARE_B = 2'd3;
  localparam logic [CFG_DATA_W-1:0] END_ALL     = 32'hFFFF_FFFF;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] kept_byte;
    logic [CHAR_W-1:0] char_count;
    logic              run_end;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ucf_in_if  in_if ();
  ucf_out_if out_if ();

  utf8_char_count_range_filter_unit #(.COUNT_BITS(CHAR_CNT_BITS)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic [BYTE_W-1:0]        seq_bytes [HELD_DEPTH];
  int unsigned              seq_held     = 0;
  int unsigned              seq_missing  = 0;
  logic [CHAR_CNT_BITS-1:0] char_pos     = '0;
  logic [CFG_DATA_W-1:0]    keep_from    = '0;
  logic [CFG_DATA_W-1:0]    keep_until   = 32'hFFFF_FFFF;
  result_t                  expected_results [$];
  result_t                  step_results [$];
  logic [BYTE_W-1:0]        text_bytes [$];

  int          n_errors     = 0;
  int          in_idle_pct  = 35;
  int          out_idle_pct = 77;
  int unsigned quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void keep_if_in_range(logic [BYTE_W-1:0] b);
    result_t r;
    if (64'(char_pos) >= 64'(keep_from) && 64'(char_pos) < 64'(keep_until)) begin
      r.kind       = KIND_DATA;
      r.kept_byte  = b;
      r.char_count = CHAR_W'(char_pos);
      r.run_end    = 1'b0;
      step_results.push_back(r);
    end
  endfunction

  function automatic void next_char();
    if (char_pos != '1) char_pos = char_pos + 1'b1;
  endfunction

  // each held byte becomes a character of its own
  function automatic void flush_seq();
    int unsigned i;
    for (i = 0; i < seq_held; i++) begin
      keep_if_in_range(seq_bytes[i]);
      next_char();
    end
    seq_held    = 0;
    seq_missing = 0;
  endfunction

  function automatic int unsigned lead_ones(logic [BYTE_W-1:0] b);
    int unsigned k;
    k = 0;
    while (k < 8 && b[7-k]) k++;
    return k;
  endfunction

  function automatic void predict_byte(logic [BYTE_W-1:0] b, logic last);
    bit          consumed;
    int unsigned ones;
    int unsigned i;
    result_t     r;
    consumed = 1'b0;
    step_results.delete();
    if (seq_missing != 0) begin
      if ((b & CONT_MASK) == CONT_CODE) begin
        if (seq_missing == 1) begin
          for (i = 0; i < seq_held; i++) keep_if_in_range(seq_bytes[i]);
          keep_if_in_range(b);
          next_char();
          seq_held    = 0;
          seq_missing = 0;
        end else if (seq_held < HELD_DEPTH) begin
          seq_bytes[seq_held] = b;
          seq_held++;
          seq_missing--;
        end
        consumed = 1'b1;
      end else begin
        flush_seq();
      end
    end
    if (!consumed) begin
      ones = lead_ones(b);
      if (ones < 2 || ones > MAX_LEAD_ONES) begin
        keep_if_in_range(b);
        next_char();
      end else begin
        seq_bytes[0] = b;
        seq_held     = 1;
        seq_missing  = ones - 1;
      end
    end
    if (last) begin
      if (seq_missing != 0) flush_seq();
      r.kind       = KIND_SUMMARY;
      r.kept_byte  = '0;
      r.char_count = CHAR_W'(char_pos);
      r.run_end    = 1'b0;
      step_results.push_back(r);
      seq_held    = 0;
      seq_missing = 0;
      char_pos    = '0;
    end
    if (step_results.size() != 0) begin
      r = step_results.pop_back();
      r.run_end = 1'b1;
      step_results.push_back(r);
    end
    foreach (step_results[j]) expected_results.push_back(step_results[j]);
  endfunction

  task automatic report_mismatch(input string msg);
    if (n_errors < MAX_REPORTS) $display("mismatch: %s", msg);
    n_errors++;
  endtask

  task automatic check_result();
    result_t seen;
    result_t want;
    seen.kind       = kind_t'(out_if.kind);
    seen.kept_byte  = out_if.kept_byte;
    seen.char_count = out_if.char_count;
    seen.run_end    = out_if.run_end;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected item kind %0d byte %02h count %0d",
                                seen.kind, seen.kept_byte, seen.char_count));
      return;
    end
    want = expected_results.pop_front();
    if (seen.kind != want.kind)
      report_mismatch($sformatf("kind expected %0d got %0d", want.kind, seen.kind));
    if (seen.kept_byte != want.kept_byte)
      report_mismatch($sformatf("kept_byte expected %02h got %02h",
                                want.kept_byte, seen.kept_byte));
    if (seen.char_count != want.char_count)
      report_mismatch($sformatf("char_count expected %0d got %0d",
                                want.char_count, seen.char_count));
    if (seen.run_end != want.run_end)
      report_mismatch($sformatf("run_end expected %0d got %0d", want.run_end, seen.run_end));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) check_result();
  end

  // counts cycles in which nothing moves
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_text();
    int unsigned i;
    for (i = 0; i < text_bytes.size(); i++) send_byte(text_bytes[i], i == text_bytes.size() - 1);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_FIRST_CHAR) keep_from = val;
    else if (idx == REG_END_CHAR) keep_until = val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic void add_lead_seq(int unsigned ones, int unsigned n_cont);
    logic [BYTE_W-1:0] lead;
    lead = (8'hFF << (8 - ones)) | (8'($urandom) & (8'hFF >> (ones + 1)));
    text_bytes.push_back(lead);
    repeat (n_cont) text_bytes.push_back(CONT_CODE | 8'($urandom_range(0, 63)));
  endfunction

  // mostly well-formed characters, some cut short, some raw noise
  function automatic void add_random_char();
    int unsigned pick;
    int unsigned ones;
    pick = $urandom_range(99);
    if (pick < 65) begin
      ones = $urandom_range(1, 6);
      if (ones == 1) text_bytes.push_back(8'($urandom_range(0, 127)));
      else add_lead_seq(ones, ones - 1);
    end else if (pick < 82) begin
      ones = $urandom_range(2, 6);
      add_lead_seq(ones, $urandom_range(0, ones - 2));
    end else begin
      text_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic set_random_window();
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    case ($urandom_range(3))
      0: begin
        lo = '0;
        hi = END_ALL;
      end
      1: begin
        lo = $urandom_range(0, 6);
        hi = lo + $urandom_range(1, 10);
      end
      2: begin
        hi = $urandom_range(0, 6);
        lo = hi + $urandom_range(0, 4);
      end
      default: begin
        lo = $urandom_range(0, 3);
        hi = $urandom;
      end
    endcase
    write_reg(REG_FIRST_CHAR, lo);
    write_reg(REG_END_CHAR, hi);
  endtask

  task automatic run_random_segment(input int n_items);
    int sent;
    int n_chars;
    sent = 0;
    set_random_window();
    while (sent < n_items) begin
      text_bytes.delete();
      n_chars = $urandom_range(1, 8);
      repeat (n_chars) add_random_char();
      sent += text_bytes.size();
      send_text();
    end
    wait_idle();
  endtask

  // ascii, lone continuation, 8 and 7 leading ones, 2, 3 and 6 byte chars,
  // broken pair, string ending inside a sequence
  task automatic test_char_forms();
    text_bytes = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'hFE, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                   8'hFC, 8'h84, 8'h80, 8'h80, 8'h80, 8'h80, 8'hC3, 8'h41, 8'hE2, 8'h82};
    send_text();
    wait_idle();
  endtask

  task automatic test_range_config();
    write_reg(REG_FIRST_CHAR, 32'd2);
    write_reg(REG_END_CHAR, 32'd5);
    write_reg(REG_SPARE_A, '0);
    write_reg(REG_SPARE_B, END_ALL);
    text_bytes = '{8'h41, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'h42, 8'h43, 8'h44};
    send_text();
    wait_idle();
    // empty window at the extremes
    write_reg(REG_FIRST_CHAR, END_ALL);
    write_reg(REG_END_CHAR, '0);
    text_bytes = '{8'hF0, 8'h9F, 8'h43};
    send_text();
    wait_idle();
  endtask

  task automatic test_random_strings();
    in_idle_pct  = 35;
    out_idle_pct = 77;
    repeat (3) run_random_segment(22);
    in_idle_pct  = 77;
    out_idle_pct = 35;
    repeat (3) run_random_segment(22);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    repeat (3) run_random_segment(22);
  endtask

  initial begin
    foreach (seq_bytes[k]) seq_bytes[k] = '0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_char_forms();
    test_range_config();
    test_random_strings();
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
